@@ rtl/nearest_symbol_range_lookup_core_assert.svh @@
// assertion macros for the symbol lookup core
`ifndef NEAREST_SYMBOL_RANGE_LOOKUP_CORE_ASSERT_SVH
`define NEAREST_SYMBOL_RANGE_LOOKUP_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define NSRL_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define NSRL_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

@@ rtl/nsrl_pkg.sv @@
// shared types and constants for the symbol lookup core
package nsrl_pkg;
  localparam int unsigned TableEntries = 16384;
  localparam int unsigned ImageLimit = 32;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_RANK   = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_RANK = 3'd4;

  localparam logic [1:0] ADDR_BIAS  = 2'd0;
  localparam logic [1:0] ADDR_SLACK = 2'd1;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] name;
    logic [4:0]  image;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_SHRD, S_SHWR, S_FIN, S_RD, S_OUT
  } state_t;

  typedef struct packed {
    logic        we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] raddr;
  } mem_ctl_t;
endpackage

@@ rtl/nsrl_table_ram.sv @@
// single-port-write, single-port-read entry memory with registered read
module nsrl_table_ram (
  input  logic                    clk,
  input  nsrl_pkg::mem_ctl_t      ctl,
  input  nsrl_pkg::entry_t        wdata,
  output nsrl_pkg::entry_t        rdata
);
  nsrl_pkg::entry_t mem [nsrl_pkg::TableEntries];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rdata <= mem[ctl.raddr];
  end
endmodule

@@ rtl/nearest_symbol_range_lookup_core.sv @@
// symbol lookup core: sorted table with binary search and shifting insert
//  channel | direction | handshake
//  in_     | input     | in_valid / in_ready
//  out_    | output    | out_valid / out_ready
//  cfg_    | apb       | psel, penable, pwrite, pready always high
// lookup: each search step passes S_SRCH then S_SWAIT, and the final entry is read in S_RD;
// steps about log2(count+1); one registered memory read per search step
// insert: same search, then a read state (S_SHRD) and a write state (S_SHWR) per shifted entry
// read by rank: S_SWAIT, S_RD, then S_OUT; clear and rejected requests go straight to S_OUT; one item in work at a time
// rst_n is synchronous; the table count is cleared, memory contents are not
// a result waits in its own output register until out_ready; the next item is
// accepted and worked on meanwhile, and waits in the out state if the register is still full
module nearest_symbol_range_lookup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_addr,
  input  logic [31:0] in_sym_size,
  input  logic [31:0] in_name_handle,
  input  logic [4:0]  in_image_id,
  input  logic [13:0] in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_addr,
  output logic [31:0] out_offset,
  output logic [31:0] out_found_name,
  output logic [4:0]  out_found_image,
  output logic [14:0] out_entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned IW = nsrl_pkg::IdxW;
  localparam int unsigned CW = nsrl_pkg::CntW;

  logic [31:0] bias_r, slack_r;
  nsrl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [CW-1:0] lo_eff, hi_eff;
  logic [1:0]  kind_r, kind_nxt;
  logic [31:0] key_r, key_nxt;
  nsrl_pkg::entry_t new_r, new_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic ovld_r, ovld_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [31:0] ofa_r, ofa_nxt, ooff_r, ooff_nxt, ofn_r, ofn_nxt;
  logic [4:0]  ofi_r, ofi_nxt;
  logic [14:0] ocnt_r, ocnt_nxt;
  logic [2:0]  res_st_r;
  logic [31:0] res_fa_r, res_off_r, res_fn_r;
  logic [4:0]  res_fi_r;
  nsrl_pkg::mem_ctl_t ctl;
  nsrl_pkg::entry_t wdata, rdata;
  logic [31:0] delta;
  logic        hit;
  logic        cfg_wr;
  logic        cmp_vld_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == nsrl_pkg::ADDR_SLACK[0]) ? slack_r : bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r  <= '0;
      slack_r <= 32'h1000;
    end else if (cfg_wr) begin
      if (paddr[2] == nsrl_pkg::ADDR_BIAS[0]) bias_r <= pwdata;
      else slack_r <= pwdata;
    end
  end

  nsrl_table_ram u_ram (.clk(clk), .ctl(ctl), .wdata(wdata), .rdata(rdata));

  assign in_ready = (state_r == nsrl_pkg::S_IDLE);
  assign delta = key_r - rdata.addr;
  assign hit = (rdata.len != 32'd0) ? (delta < rdata.len) : (delta <= slack_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; lo_nxt = lo_r; hi_nxt = hi_r; pos_nxt = pos_r; mid_nxt = mid_r;
    lo_eff = lo_r; hi_eff = hi_r;
    kind_nxt = kind_r; key_nxt = key_r; new_nxt = new_r;
    ovld_nxt = ovld_r && !out_ready;
    ost_nxt = ost_r; ofa_nxt = ofa_r; ooff_nxt = ooff_r; ofn_nxt = ofn_r;
    ofi_nxt = ofi_r; ocnt_nxt = ocnt_r;
    ctl.we = 1'b0; ctl.waddr = '0; ctl.raddr = mid_r[IW-1:0];
    wdata = rdata;
    case (state_r)
      nsrl_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          kind_nxt = in_kind;
          key_nxt = in_addr;
          new_nxt.len = in_sym_size;
          new_nxt.name = in_name_handle;
          new_nxt.image = (32'(in_image_id) >= nsrl_pkg::ImageLimit)
                          ? 5'(nsrl_pkg::ImageLimit - 1) : in_image_id;
          new_nxt.addr = in_addr + bias_r;
          lo_nxt = '0; hi_nxt = cnt_r;
          ost_nxt = nsrl_pkg::ST_DONE; ofa_nxt = '0; ooff_nxt = '0;
          ofn_nxt = '0; ofi_nxt = '0;
          case (in_kind)
            nsrl_pkg::KIND_INSERT: begin
              if (cnt_r >= CW'(nsrl_pkg::TableEntries)) begin
                ost_nxt = nsrl_pkg::ST_FULL; state_nxt = nsrl_pkg::S_OUT;
              end else if (in_addr == 32'd0) begin
                ost_nxt = nsrl_pkg::ST_ZERO; state_nxt = nsrl_pkg::S_OUT;
              end else begin
                key_nxt = in_addr + bias_r; state_nxt = nsrl_pkg::S_SRCH;
              end
            end
            nsrl_pkg::KIND_LOOKUP: state_nxt = nsrl_pkg::S_SRCH;
            nsrl_pkg::KIND_RANK: begin
              if (CW'(in_rank) >= cnt_r) begin
                ost_nxt = nsrl_pkg::ST_RANK; state_nxt = nsrl_pkg::S_OUT;
              end else begin
                mid_nxt = CW'(in_rank); state_nxt = nsrl_pkg::S_SWAIT;
              end
            end
            default: begin
              cnt_nxt = '0; state_nxt = nsrl_pkg::S_OUT;
            end
          endcase
        end
      end
      nsrl_pkg::S_SRCH: begin
        // narrow the interval with the entry read at mid
        if (cmp_vld_r) begin
          if (rdata.addr <= key_r) lo_eff = mid_r + 1'b1;
          else hi_eff = mid_r;
        end
        lo_nxt = lo_eff; hi_nxt = hi_eff;
        if (lo_eff < hi_eff) begin
          mid_nxt = lo_eff + ((hi_eff - lo_eff) >> 1);
          state_nxt = nsrl_pkg::S_SWAIT;
        end else begin
          pos_nxt = lo_eff;
          if (kind_r == nsrl_pkg::KIND_INSERT) begin
            mid_nxt = cnt_r;
            state_nxt = nsrl_pkg::S_FIN;
            if (cnt_r != lo_eff) begin
              mid_nxt = cnt_r - 1'b1;
              state_nxt = nsrl_pkg::S_SHRD;
            end
          end else if (lo_eff == '0) begin
            ost_nxt = nsrl_pkg::ST_MISS; state_nxt = nsrl_pkg::S_OUT;
          end else begin
            mid_nxt = lo_eff - 1'b1; state_nxt = nsrl_pkg::S_RD;
          end
        end
      end
      nsrl_pkg::S_SWAIT: begin
        state_nxt = (kind_r == nsrl_pkg::KIND_RANK) ? nsrl_pkg::S_RD : nsrl_pkg::S_SRCH;
        ctl.raddr = mid_r[IW-1:0];
      end
      nsrl_pkg::S_SHRD: state_nxt = nsrl_pkg::S_SHWR;
      nsrl_pkg::S_SHWR: begin
        // read data of mid moves up one slot
        ctl.we = 1'b1; ctl.waddr = IW'(mid_r + 1'b1);
        if (mid_r == pos_r) begin
          state_nxt = nsrl_pkg::S_FIN;
        end else begin
          mid_nxt = mid_r - 1'b1; state_nxt = nsrl_pkg::S_SHRD;
        end
      end
      nsrl_pkg::S_FIN: begin
        ctl.we = 1'b1; ctl.waddr = pos_r[IW-1:0]; wdata = new_r;
        cnt_nxt = cnt_r + 1'b1;
        ofa_nxt = new_r.addr; ofn_nxt = new_r.name; ofi_nxt = new_r.image;
        state_nxt = nsrl_pkg::S_OUT;
      end
      nsrl_pkg::S_RD: begin
        if (kind_r == nsrl_pkg::KIND_RANK) begin
          ofa_nxt = rdata.addr; ofn_nxt = rdata.name; ofi_nxt = rdata.image;
        end else if (hit) begin
          ofa_nxt = rdata.addr; ooff_nxt = delta; ofn_nxt = rdata.name;
          ofi_nxt = rdata.image;
        end else begin
          ost_nxt = nsrl_pkg::ST_MISS;
        end
        state_nxt = nsrl_pkg::S_OUT;
      end
      nsrl_pkg::S_OUT: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt = 1'b1; ocnt_nxt = 15'(cnt_r); state_nxt = nsrl_pkg::S_IDLE;
        end
      end
      default: state_nxt = nsrl_pkg::S_IDLE;
    endcase
    // read the next mid (or the final entry of a lookup) as soon as it is known
    if (state_r == nsrl_pkg::S_SRCH) begin
      ctl.raddr = mid_nxt[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsrl_pkg::S_IDLE;
      cnt_r <= '0;
      ovld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovld_r <= ovld_nxt;
      cmp_vld_r <= (state_r == nsrl_pkg::S_SWAIT) && (kind_r != nsrl_pkg::KIND_RANK);
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt; key_r <= key_nxt; new_r <= new_nxt; mid_r <= mid_nxt;
    pos_r <= pos_nxt;
    ost_r <= ost_nxt; ofa_r <= ofa_nxt; ooff_r <= ooff_nxt; ofn_r <= ofn_nxt;
    ofi_r <= ofi_nxt; ocnt_r <= ocnt_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt;
    // output register, loaded as the finished item leaves the out state
    if (state_r == nsrl_pkg::S_OUT && (!ovld_r || out_ready)) begin
      res_st_r <= ost_r; res_fa_r <= ofa_r; res_off_r <= ooff_r;
      res_fn_r <= ofn_r; res_fi_r <= ofi_r;
    end
  end

  assign out_valid = ovld_r;
  assign out_status = res_st_r;
  assign out_found_addr = res_fa_r;
  assign out_offset = res_off_r;
  assign out_found_name = res_fn_r;
  assign out_found_image = res_fi_r;
  assign out_entry_count = ocnt_r;

`include "nearest_symbol_range_lookup_core_assert.svh"
  `NSRL_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= CW'(nsrl_pkg::TableEntries))
  `NSRL_ASSERT_IMP(a_ready_idle, in_ready, state_r == nsrl_pkg::S_IDLE)
  `NSRL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))
endmodule
